FILE: hdl/rwe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwe_pkg
// Shared types, widths and codes for the radio watchdog escalation block.
// ----------------------------------------------------------------------------
package rwe_pkg;

    localparam int TIME_W     = 32;
    localparam int STATE_W    = 5;
    localparam int COUNT_W    = 4;
    localparam int ACTION_W   = 3;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLUSHES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESETS     = 2'd3;

    // configuration reset values
    localparam logic [TIME_W-1:0]  RST_CHECK_INTERVAL = 32'd5000;
    localparam logic [TIME_W-1:0]  RST_ESC_WINDOW     = 32'd60000;
    localparam logic [COUNT_W-1:0] RST_MAX_FLUSHES    = 4'd3;
    localparam logic [COUNT_W-1:0] RST_MAX_RESETS     = 4'd3;

    // radio main state codes
    localparam logic [STATE_W-1:0] ST_IDLE     = 5'd1;
    localparam logic [STATE_W-1:0] ST_CAL_LO   = 5'd3;
    localparam logic [STATE_W-1:0] ST_CAL_HI   = 5'd12;
    localparam logic [STATE_W-1:0] ST_RX       = 5'd13;
    localparam logic [STATE_W-1:0] ST_RX_END   = 5'd14;
    localparam logic [STATE_W-1:0] ST_RX_RST   = 5'd15;
    localparam logic [STATE_W-1:0] ST_OVERFLOW = 5'd17;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_SRX        = 3'd1,
        ACT_FLUSH_RX   = 3'd2,
        ACT_FLUSH_BOTH = 3'd3,
        ACT_RESET      = 3'd4,
        ACT_FAILED     = 3'd5
    } action_t;

    typedef struct packed {
        logic [TIME_W-1:0]  check_interval_ms;
        logic [TIME_W-1:0]  escalation_window_ms;
        logic [COUNT_W-1:0] max_flushes;
        logic [COUNT_W-1:0] max_resets;
    } cfg_t;

    typedef struct packed {
        action_t            action;
        logic [COUNT_W-1:0] flushes_in_window;
        logic [COUNT_W-1:0] resets_in_window;
        logic               failed;
        logic [TOTAL_W-1:0] recovery_total;
    } res_t;

endpackage

FILE: hdl/rwe_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwe_in_if
// Input channel: timestamp and radio main state, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rwe_in_if;
    logic                        valid;
    logic                        ready;
    logic [rwe_pkg::TIME_W-1:0]  now_ms;
    logic [rwe_pkg::STATE_W-1:0] radio_state;

    modport source (output valid, output now_ms, output radio_state, input ready);
    modport sink   (input valid, input now_ms, input radio_state, output ready);
endinterface

FILE: hdl/rwe_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwe_out_if
// Result channel: recovery action and escalation status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rwe_out_if;
    logic                         valid;
    logic                         ready;
    logic [rwe_pkg::ACTION_W-1:0] action;
    logic [rwe_pkg::COUNT_W-1:0]  flushes_in_window;
    logic [rwe_pkg::COUNT_W-1:0]  resets_in_window;
    logic                         failed;
    logic [rwe_pkg::TOTAL_W-1:0]  recovery_total;

    modport source (output valid, output action, output flushes_in_window,
                    output resets_in_window, output failed, output recovery_total,
                    input ready);
    modport sink   (input valid, input action, input flushes_in_window,
                    input resets_in_window, input failed, input recovery_total,
                    output ready);
endinterface

FILE: hdl/rwe_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwe_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rwe_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rwe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output rwe_pkg::cfg_t                   cfg
);
    import rwe_pkg::*;

    cfg_t cfg_reg;

    // register writes, masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_interval_ms    <= RST_CHECK_INTERVAL;
            cfg_reg.escalation_window_ms <= RST_ESC_WINDOW;
            cfg_reg.max_flushes          <= RST_MAX_FLUSHES;
            cfg_reg.max_resets           <= RST_MAX_RESETS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHECK_INTERVAL: cfg_reg.check_interval_ms    <= cfg_wdata[TIME_W-1:0];
                CFG_ESC_WINDOW:     cfg_reg.escalation_window_ms <= cfg_wdata[TIME_W-1:0];
                CFG_MAX_FLUSHES:    cfg_reg.max_flushes          <= cfg_wdata[COUNT_W-1:0];
                CFG_MAX_RESETS:     cfg_reg.max_resets           <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/rwe_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwe_check
// Health check evaluation and escalation state; state commits on advance.
// ----------------------------------------------------------------------------
module rwe_check (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rwe_pkg::cfg_t                cfg,
    input  logic                         advance,
    input  logic [rwe_pkg::TIME_W-1:0]   now_ms,
    input  logic [rwe_pkg::STATE_W-1:0]  radio_state,
    output rwe_pkg::res_t                res
);
    import rwe_pkg::*;

    logic [TIME_W-1:0]  last_check_reg, last_check_next;
    logic [TIME_W-1:0]  window_start_reg, window_start_next;
    logic [COUNT_W-1:0] flush_cnt_reg, flush_cnt_next;
    logic [COUNT_W-1:0] reset_cnt_reg, reset_cnt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               failed_reg, failed_next;

    logic [TIME_W-1:0]  since_check;
    logic [TIME_W-1:0]  since_window;
    logic               due;
    logic               is_rx;
    logic               settling;
    logic               expired;
    logic [COUNT_W-1:0] flush_base;
    logic [COUNT_W-1:0] reset_base;
    action_t            action;

    // elapsed times, modulo 2^32
    assign since_check  = now_ms - last_check_reg;
    assign since_window = now_ms - window_start_reg;
    assign due          = (since_check >= cfg.check_interval_ms);
    assign expired      = (since_window > cfg.escalation_window_ms);
    assign is_rx        = (radio_state == ST_RX);
    assign settling     = ((radio_state >= ST_CAL_LO) && (radio_state <= ST_CAL_HI))
                          || (radio_state == ST_RX_END) || (radio_state == ST_RX_RST);

    // escalation decision
    always_comb
    begin
        last_check_next   = last_check_reg;
        window_start_next = window_start_reg;
        flush_cnt_next    = flush_cnt_reg;
        reset_cnt_next    = reset_cnt_reg;
        total_next        = total_reg;
        failed_next       = failed_reg;
        action            = ACT_NONE;
        flush_base        = flush_cnt_reg;
        reset_base        = reset_cnt_reg;
        if (due)
        begin
            last_check_next = now_ms;
            if (is_rx)
            begin
                flush_cnt_next    = '0;
                reset_cnt_next    = '0;
                window_start_next = now_ms;
            end
            else if (!settling)
            begin
                total_next = total_reg + TOTAL_W'(1);
                if (expired)
                begin
                    flush_base        = '0;
                    reset_base        = '0;
                    window_start_next = now_ms;
                end
                flush_cnt_next = flush_base;
                reset_cnt_next = reset_base;
                priority if (radio_state == ST_IDLE)
                begin
                    action = ACT_SRX;
                end
                else if (flush_base < cfg.max_flushes)
                begin
                    flush_cnt_next = flush_base + COUNT_W'(1);
                    action = (radio_state == ST_OVERFLOW) ? ACT_FLUSH_RX : ACT_FLUSH_BOTH;
                end
                else if (reset_base < cfg.max_resets)
                begin
                    reset_cnt_next = reset_base + COUNT_W'(1);
                    action = ACT_RESET;
                end
                else
                begin
                    failed_next = 1'b1;
                    action = ACT_FAILED;
                end
            end
        end
    end

    // watchdog state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_check_reg   <= '0;
            window_start_reg <= '0;
            flush_cnt_reg    <= '0;
            reset_cnt_reg    <= '0;
            total_reg        <= '0;
            failed_reg       <= 1'b0;
        end
        else if (advance)
        begin
            last_check_reg   <= last_check_next;
            window_start_reg <= window_start_next;
            flush_cnt_reg    <= flush_cnt_next;
            reset_cnt_reg    <= reset_cnt_next;
            total_reg        <= total_next;
            failed_reg       <= failed_next;
        end
    end

    assign res.action            = action;
    assign res.flushes_in_window = flush_cnt_next;
    assign res.resets_in_window  = reset_cnt_next;
    assign res.failed            = failed_next;
    assign res.recovery_total    = total_next;

endmodule

FILE: hdl/radio_watchdog_escalation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_watchdog_escalation
// Radio watchdog: periodic health checks with escalating recovery actions.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one word per health sample, a millisecond timestamp and the
//            radio main state code, valid/ready handshake.
//   result : one word per accepted item: recovery action, flush and reset
//            counts in the current window, sticky failed flag, total count
//            of unhealthy checks.
//   cfg    : plain write port for check interval, escalation window and the
//            flush and reset limits; write only while the block is idle.
//   An accepted item is loaded into the input register, then into the result
//   register once that is free, which raises result.valid. Throughput is one
//   word per cycle while the receiver does not stall; the watchdog state
//   commits as a word moves into the result register, so the next word is
//   checked against the committed state.
//   Reset clears all watchdog state and loads the default configuration.
//   When the receiver stalls, the result register and then the input
//   register hold their words and item.ready falls; nothing is dropped.
// ----------------------------------------------------------------------------
module radio_watchdog_escalation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rwe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    rwe_in_if.sink                          item,
    rwe_out_if.source                       result
);
    import rwe_pkg::*;

    cfg_t               cfg;
    res_t               res;
    res_t               res_reg;
    logic               out_valid_reg;
    logic               in_valid_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [STATE_W-1:0] state_reg;
    logic               out_free;
    logic               advance;
    logic               in_take;

    // configuration registers
    rwe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // pipeline flow control
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;
    assign in_take    = item.valid && item.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg   <= item.now_ms;
            state_reg <= item.radio_state;
        end
    end

    // check evaluation and watchdog state
    rwe_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .advance     (advance),
        .now_ms      (now_reg),
        .radio_state (state_reg),
        .res         (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.action            = res_reg.action;
    assign result.flushes_in_window = res_reg.flushes_in_window;
    assign result.resets_in_window  = res_reg.resets_in_window;
    assign result.failed            = res_reg.failed;
    assign result.recovery_total    = res_reg.recovery_total;

`ifndef NO_ASSERTIONS
    // a failure action always comes with the sticky flag set
    a_fail_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.action == ACT_FAILED)) |-> res_reg.failed)
        else $error("failure action without failed flag");

    // once reported failed, later words stay failed
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_reg.failed && $past(advance)) |-> res.failed)
        else $error("failed flag cleared");

    // a stalled result word is not replaced by the next one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !advance)
        else $error("result register overwritten while stalled");
`endif

endmodule

FILE: dv/radio_watchdog_escalation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_watchdog_escalation_test
// Self-checking bench for the radio watchdog. Timestamp and radio state words
// go in through a bursty sender. Results come out through a receiver that
// stalls on patterns of its own. A scoreboard class keeps its own copy of the
// watchdog state and configuration and predicts every result word. A directed
// escalation sequence runs first. Then come phases of random words under
// several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module radio_watchdog_escalation_test;
    import rwe_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int PHASE_WORDS    = 250;
    localparam int PAUSE_WORD     = 120;
    localparam int HOLD_AT_RESULT = 700;
    localparam int HOLD_CYCLES    = 400;
    localparam int DIRECTED_WORDS = 22;

    // state codes with no name of their own in the package, all unhealthy
    localparam logic [STATE_W-1:0] ST_CODE_MIN  = '0;
    localparam logic [STATE_W-1:0] ST_CODE_MAX  = '1;
    localparam logic [STATE_W-1:0] ST_GAP_LO    = ST_IDLE + 1'b1;
    localparam logic [STATE_W-1:0] ST_BELOW_OVF = ST_OVERFLOW - 1'b1;
    localparam logic [STATE_W-1:0] ST_ABOVE_OVF = ST_OVERFLOW + 1'b1;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE} sink_mode_e;

    // escalation run under reset settings, then window expiry and time wrap
    localparam logic [TIME_W-1:0] DIR_MS [DIRECTED_WORDS] = '{
        32'd0, 32'd4999, 32'd5000, 32'd10000, 32'd15000, 32'd20000,
        32'd25000, 32'd30000, 32'd35000, 32'd40000, 32'd45000, 32'd50000,
        32'd55000, 32'd60000, 32'd66000, 32'd71000, 32'd76000, 32'hFFFF_FFFF,
        32'h0000_0FFF, 32'h0000_1387, 32'hAAAA_AAAA, 32'h5555_5555
    };
    localparam logic [STATE_W-1:0] DIR_STATE [DIRECTED_WORDS] = '{
        ST_OVERFLOW, ST_CODE_MIN, ST_IDLE, ST_OVERFLOW, ST_CODE_MIN, ST_CODE_MAX,
        ST_BELOW_OVF, ST_GAP_LO, ST_ABOVE_OVF, ST_OVERFLOW, ST_CAL_LO, ST_CAL_HI,
        ST_RX_END, ST_RX_RST, ST_ABOVE_OVF, ST_RX, ST_OVERFLOW, ST_CODE_MAX,
        ST_OVERFLOW, ST_CAL_HI, ST_IDLE, ST_RX
    };

    // predicted watchdog state and the queue of result words still to come
    class watchdog_scoreboard;
        cfg_t               regs;
        logic [TIME_W-1:0]  last_check;
        logic [TIME_W-1:0]  window_start;
        logic [COUNT_W-1:0] flush_cnt;
        logic [COUNT_W-1:0] reset_cnt;
        logic [TOTAL_W-1:0] unhealthy_total;
        logic               failed_flag;
        res_t               expected_q[$];
        int unsigned        errors;

        function new();
            regs.check_interval_ms    = RST_CHECK_INTERVAL;
            regs.escalation_window_ms = RST_ESC_WINDOW;
            regs.max_flushes          = RST_MAX_FLUSHES;
            regs.max_resets           = RST_MAX_RESETS;
            last_check      = '0;
            window_start    = '0;
            flush_cnt       = '0;
            reset_cnt       = '0;
            unhealthy_total = '0;
            failed_flag     = 1'b0;
            errors          = 0;
        endfunction

        function void apply_cfg(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_CHECK_INTERVAL: regs.check_interval_ms    = data[TIME_W-1:0];
                CFG_ESC_WINDOW:     regs.escalation_window_ms = data[TIME_W-1:0];
                CFG_MAX_FLUSHES:    regs.max_flushes          = data[COUNT_W-1:0];
                CFG_MAX_RESETS:     regs.max_resets           = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted word: run the health check and queue its result
        function void note_word(input logic [TIME_W-1:0] now_ms,
                                input logic [STATE_W-1:0] st);
            action_t           act;
            logic [TIME_W-1:0] since_check;
            logic [TIME_W-1:0] since_window;
            res_t              r;
            act = ACT_NONE;
            since_check = now_ms - last_check;
            if (since_check >= regs.check_interval_ms) begin
                last_check = now_ms;
                if (st == ST_RX) begin
                    flush_cnt    = '0;
                    reset_cnt    = '0;
                    window_start = now_ms;
                end
                else if (!(st >= ST_CAL_LO && st <= ST_CAL_HI) &&
                         st != ST_RX_END && st != ST_RX_RST) begin
                    unhealthy_total = unhealthy_total + 1'b1;
                    since_window = now_ms - window_start;
                    if (since_window > regs.escalation_window_ms) begin
                        flush_cnt    = '0;
                        reset_cnt    = '0;
                        window_start = now_ms;
                    end
                    if (st == ST_IDLE)
                        act = ACT_SRX;
                    else if (flush_cnt < regs.max_flushes) begin
                        flush_cnt = flush_cnt + 1'b1;
                        act = (st == ST_OVERFLOW) ? ACT_FLUSH_RX : ACT_FLUSH_BOTH;
                    end
                    else if (reset_cnt < regs.max_resets) begin
                        reset_cnt = reset_cnt + 1'b1;
                        act = ACT_RESET;
                    end
                    else begin
                        failed_flag = 1'b1;
                        act = ACT_FAILED;
                    end
                end
            end
            r.action            = act;
            r.flushes_in_window = flush_cnt;
            r.resets_in_window  = reset_cnt;
            r.failed            = failed_flag;
            r.recovery_total    = unhealthy_total;
            expected_q.push_back(r);
        endfunction

        function void check_word(input res_t got);
            res_t want;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: action %0d", got.action);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.action !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, got.action);
                errors++;
            end
            if (got.flushes_in_window !== want.flushes_in_window) begin
                $error("flushes_in_window: expected %0d, got %0d",
                       want.flushes_in_window, got.flushes_in_window);
                errors++;
            end
            if (got.resets_in_window !== want.resets_in_window) begin
                $error("resets_in_window: expected %0d, got %0d",
                       want.resets_in_window, got.resets_in_window);
                errors++;
            end
            if (got.failed !== want.failed) begin
                $error("failed: expected %0d, got %0d", want.failed, got.failed);
                errors++;
            end
            if (got.recovery_total !== want.recovery_total) begin
                $error("recovery_total: expected %0d, got %0d",
                       want.recovery_total, got.recovery_total);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic [TIME_W-1:0]     stim_ms;
    int unsigned           cycle_count;
    watchdog_scoreboard    sb;

    rwe_in_if  item_ch ();
    rwe_out_if result_ch ();

    radio_watchdog_escalation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run guard
    initial
    begin : cycle_guard
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // radio state mix: mostly unhealthy so escalation gets deep
    function automatic logic [STATE_W-1:0] pick_state();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return ST_RX;
        if (roll < 20)
            return ST_IDLE;
        if (roll < 32)
            return STATE_W'($urandom_range(ST_CAL_LO, ST_RX_RST));
        if (roll < 55)
            return ST_OVERFLOW;
        return STATE_W'($urandom_range(ST_CODE_MIN, ST_CODE_MAX));
    endfunction

    // time advance around the check interval, with boundaries and big jumps
    function automatic logic [TIME_W-1:0] pick_step();
        int unsigned       roll;
        logic [TIME_W-1:0] iv;
        logic [TIME_W-1:0] span;
        iv   = sb.regs.check_interval_ms;
        span = (iv > 32'd50000) ? 32'd50000 : iv;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return iv;
        if (roll < 15)
            return iv - 1'b1;
        if (roll < 20)
            return $urandom();
        return $urandom_range(0, span + span / 2 + 1);
    endfunction

    // offer one word and hold it until taken
    task automatic drive_word(input logic [TIME_W-1:0] t, input logic [STATE_W-1:0] s);
        item_ch.valid       <= 1'b1;
        item_ch.now_ms      <= t;
        item_ch.radio_state <= s;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        sb.note_word(t, s);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles == 0)
            return;
        item_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop offering until every predicted word is back, then let the pipe settle
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all four registers back to back, only while the block is idle
    task automatic program_regs(input logic [CFG_DATA_W-1:0] interval,
                                input logic [CFG_DATA_W-1:0] window,
                                input logic [CFG_DATA_W-1:0] flushes,
                                input logic [CFG_DATA_W-1:0] resets);
        logic [CFG_DATA_W-1:0] vals [4];
        vals[CFG_CHECK_INTERVAL] = interval;
        vals[CFG_ESC_WINDOW]     = window;
        vals[CFG_MAX_FLUSHES]    = flushes;
        vals[CFG_MAX_RESETS]     = resets;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.apply_cfg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        for (int i = 0; i < DIRECTED_WORDS; i++)
            drive_word(DIR_MS[i], DIR_STATE[i]);
        wait_drained();
    endtask

    // random words in bursts; pause_at of zero means no mid-phase drain
    task automatic run_phase(input int unsigned words, input int unsigned pause_at);
        int unsigned       sent;
        int unsigned       burst;
        logic [TIME_W-1:0] t;
        logic [STATE_W-1:0] s;
        sent    = 0;
        stim_ms = $urandom();
        while (sent < words)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < words; k++)
            begin
                // now and then land right on the window edge
                if ($urandom_range(0, 19) == 0)
                    t = sb.window_start + sb.regs.escalation_window_ms
                        + TIME_W'($urandom_range(0, 1));
                else
                    t = stim_ms + pick_step();
                s = pick_state();
                stim_ms = t;
                drive_word(t, s);
                sent++;
                if (sent == pause_at)
                    wait_drained();
            end
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
        wait_drained();
    endtask

    // result receiver: checks taken words, stalls on its own pattern
    initial
    begin : result_sink
        sink_mode_e  mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        int unsigned results_seen;
        logic        want_ready;
        res_t        got;
        result_ch.ready = 1'b0;
        mode         = SINK_OPEN;
        mode_left    = 0;
        hold_left    = 0;
        tick         = 0;
        results_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.action            = action_t'(result_ch.action);
                got.flushes_in_window = result_ch.flushes_in_window;
                got.resets_in_window  = result_ch.resets_in_window;
                got.failed            = result_ch.failed;
                got.recovery_total    = result_ch.recovery_total;
                sb.check_word(got);
                results_seen++;
                // one long hold-off so the block backs up onto its input
                if (results_seen == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_e'($urandom_range(SINK_OPEN, SINK_SPARSE));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (mode)
                SINK_OPEN:   want_ready = 1'b1;
                SINK_COIN:   want_ready = 1'($urandom_range(0, 1));
                SINK_MOSTLY: want_ready = (tick % 4) != 0;
                default:     want_ready = (tick % 4) == 0;
            endcase
            if (hold_left != 0)
            begin
                want_ready = 1'b0;
                hold_left--;
            end
            result_ch.ready <= want_ready;
        end
    end

    // main sequence
    initial
    begin
        sb = new();
        item_ch.valid       = 1'b0;
        item_ch.now_ms      = '0;
        item_ch.radio_state = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        stim_ms   = '0;
        rst_n     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // every word checked, window expired whenever time moves on, no flushes or resets
        program_regs(32'd0, 32'd0, 32'd0, 32'd0);
        run_phase(PHASE_WORDS, 0);
        // fast checks, top limits
        program_regs(32'd1, 32'd40, 32'd15, 32'd15);
        run_phase(PHASE_WORDS, 0);
        // short window, small limits, one full drain part way through
        program_regs(32'd10, 32'd200, 32'd2, 32'd1);
        run_phase(PHASE_WORDS, PAUSE_WORD);
        // widest values; limit writes carry upper bits that must be dropped
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF3, 32'h1234_567F);
        run_phase(PHASE_WORDS, 0);
        // back to the reset settings
        program_regs(RST_CHECK_INTERVAL, RST_ESC_WINDOW, CFG_DATA_W'(RST_MAX_FLUSHES),
                     CFG_DATA_W'(RST_MAX_RESETS));
        run_phase(PHASE_WORDS, 0);
        program_regs($urandom_range(0, 40), $urandom_range(0, 400), $urandom(), $urandom());
        run_phase(PHASE_WORDS, 0);
        program_regs(32'd3, 32'd25, 32'd1, 32'd4);
        run_phase(PHASE_WORDS, 0);
        // one-tick window, reset level skipped
        program_regs(32'd2, 32'd1, 32'd15, 32'd0);
        run_phase(PHASE_WORDS, 0);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
